### sv/mbrp_pkg.sv
// mbrp_pkg: shared types, constants and the crc-16/modbus byte step
// for the modbus rtu response parser; no dependencies
`default_nettype none

package mbrp_pkg;

  localparam int unsigned BROADCAST_ADDRESS = 0;
  localparam int unsigned MAX_FRAME_BYTES   = 256;

  localparam int unsigned POS_W     = 9;
  localparam int unsigned TOTAL_W   = POS_W + 1;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [15:0] CRC_SEED = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [CFG_IDX_W-1:0] CFG_READ_FC  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_FC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_REG = 2'd2;

  localparam logic [0:0] KIND_DATA   = 1'b0;
  localparam logic [0:0] KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    CLS_DATA       = 2'd0,
    CLS_ADDR_READ  = 2'd1,
    CLS_ADDR_WRITE = 2'd2,
    CLS_NONE       = 2'd3
  } mbrp_class_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } mbrp_in_t;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] value_word;
    logic [5:0]  value_index;
    logic        frame_ok;
    logic [1:0]  frame_type;
    logic [7:0]  station_address;
  } mbrp_out_t;

  typedef struct packed {
    logic [7:0]  read_fc;
    logic [7:0]  write_fc;
    logic [15:0] addr_reg;
  } mbrp_cfg_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### sv/mbrp_frame.sv
// mbrp_frame: per-frame state, crc check, classification and result build
// depends on mbrp_pkg
`default_nettype none

module mbrp_frame (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire mbrp_pkg::mbrp_in_t  item_i,
  input  wire mbrp_pkg::mbrp_cfg_t cfg_i,
  output logic                    res_valid_o,
  output mbrp_pkg::mbrp_out_t     res_o
);
  import mbrp_pkg::*;

  logic [15:0]      crc_q, crc_d;
  logic [POS_W-1:0] pos_q, pos_d;
  mbrp_class_e      cls_q, cls_d;
  logic [7:0]       dcount_q, dcount_d;
  logic [23:0]      wbytes_q, wbytes_d;
  logic [5:0]       wcount_q, wcount_d;
  logic [7:0]       pend_q, pend_d;
  logic             rmatch_q, rmatch_d;
  logic [7:0]       own_q, own_d;

  logic [7:0]         b;
  logic [POS_W-1:0]   rel;
  logic [TOTAL_W-1:0] total;
  mbrp_class_e        cls_end;
  logic               ok;
  logic               emit;
  logic [31:0]        word;

  always_comb begin
    b        = item_i.rx_byte;
    crc_d    = crc_byte(crc_q, b);
    cls_d    = cls_q;
    dcount_d = dcount_q;
    wbytes_d = wbytes_q;
    wcount_d = wcount_q;
    pend_d   = pend_q;
    rmatch_d = rmatch_q;
    own_d    = own_q;
    emit     = 1'b0;
    word     = {wbytes_q[15:8], wbytes_q[7:0], b, wbytes_q[23:16]};
    rel      = pos_q - POS_W'(3);
    ok       = 1'b0;
    total    = {1'b0, pos_q} + TOTAL_W'(1);
    cls_end  = CLS_NONE;
    res_valid_o = 1'b0;
    res_o    = '0;

    if (pos_q == '0) begin
      if (b == own_q) begin
        cls_d = CLS_DATA;
      end else if (b == 8'(BROADCAST_ADDRESS)) begin
        cls_d = CLS_ADDR_READ;
      end else begin
        cls_d = CLS_NONE;
      end
    end else if (pos_q == POS_W'(1)) begin
      if (cls_q == CLS_DATA) begin
        cls_d = (b == cfg_i.read_fc) ? CLS_DATA : CLS_NONE;
      end else if (cls_q == CLS_ADDR_READ) begin
        if (b == cfg_i.read_fc) begin
          cls_d = CLS_ADDR_READ;
        end else if (b == cfg_i.write_fc) begin
          cls_d = CLS_ADDR_WRITE;
        end else begin
          cls_d = CLS_NONE;
        end
      end
    end else if (cls_q == CLS_DATA || cls_q == CLS_ADDR_READ) begin
      if (pos_q == POS_W'(2)) begin
        dcount_d = b;
      end else if (rel < {1'b0, dcount_q}) begin
        if (cls_q == CLS_ADDR_READ) begin
          pend_d   = b;
          rmatch_d = 1'b1;
        end else begin
          case (rel[1:0])
            2'd0:    wbytes_d = {wbytes_q[23:8], b};
            2'd1:    wbytes_d = {wbytes_q[23:16], b, wbytes_q[7:0]};
            2'd2:    wbytes_d = {b, wbytes_q[15:0]};
            default: begin
              wbytes_d = '0;
              emit     = 1'b1;
            end
          endcase
        end
      end
    end else if (cls_q == CLS_ADDR_WRITE) begin
      if (pos_q == POS_W'(2)) begin
        wbytes_d = {16'h0000, b};
      end else if (pos_q == POS_W'(3)) begin
        rmatch_d = ({wbytes_q[7:0], b} == cfg_i.addr_reg);
      end else if (pos_q == POS_W'(5)) begin
        pend_d = b;
      end
    end

    pos_d = (pos_q != '1) ? pos_q + POS_W'(1) : pos_q;

    if (item_i.frame_end) begin
      cls_end = (pos_q == '0) ? CLS_NONE : cls_d;
      if (cls_end == CLS_DATA || cls_end == CLS_ADDR_READ) begin
        ok = (total == {2'b00, dcount_d} + TOTAL_W'(5));
      end else if (cls_end == CLS_ADDR_WRITE) begin
        ok = (total == TOTAL_W'(8));
      end
      if (total > TOTAL_W'(MAX_FRAME_BYTES) || crc_d != '0) begin
        ok = 1'b0;
      end
      if (ok && cls_end != CLS_DATA && rmatch_d) begin
        own_d = pend_d;
      end
      res_valid_o           = 1'b1;
      res_o.result_kind     = KIND_STATUS;
      res_o.value_index     = wcount_q;
      res_o.frame_ok        = ok;
      res_o.frame_type      = cls_end;
      res_o.station_address = own_d;
      crc_d    = CRC_SEED;
      pos_d    = '0;
      cls_d    = CLS_NONE;
      dcount_d = '0;
      wbytes_d = '0;
      wcount_d = '0;
      pend_d   = '0;
      rmatch_d = 1'b0;
    end else if (emit) begin
      res_valid_o           = 1'b1;
      res_o.result_kind     = KIND_DATA;
      res_o.value_word      = word;
      res_o.value_index     = wcount_q;
      res_o.frame_type      = CLS_DATA;
      res_o.station_address = own_q;
      wcount_d = wcount_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q    <= CRC_SEED;
      pos_q    <= '0;
      cls_q    <= CLS_NONE;
      dcount_q <= '0;
      wbytes_q <= '0;
      wcount_q <= '0;
      pend_q   <= '0;
      rmatch_q <= 1'b0;
      own_q    <= '0;
    end else if (step_i) begin
      crc_q    <= crc_d;
      pos_q    <= pos_d;
      cls_q    <= cls_d;
      dcount_q <= dcount_d;
      wbytes_q <= wbytes_d;
      wcount_q <= wcount_d;
      pend_q   <= pend_d;
      rmatch_q <= rmatch_d;
      own_q    <= own_d;
    end
  end

endmodule

`default_nettype wire

### sv/modbus_rtu_response_parser.sv
// modbus_rtu_response_parser: top level with config registers, input register
// and result register; depends on mbrp_pkg and mbrp_frame
//
// usage:
//   input channel carries one response byte per transaction plus frame_end on
//   the last byte of a frame; output channel carries data words and one status
//   transaction per frame end
//   a byte is taken every cycle while in_stall_o is low; it waits in the input
//   register, then its result, if any, is loaded into the result register when
//   the byte moves on; the crc and frame logic handle a whole byte between those
//   two registers, so throughput is one byte per cycle while the output is not stalled
//   a stall on the output holds the result register; in_stall_o rises when a byte
//   waits in the input register behind a stalled result and falls once it is taken
//   the config port writes read function code (index 0), write function code
//   (index 1) or address register number (index 2); other indexes are ignored
//   reset clears all frame state, sets station address 0 and restores the
//   default function codes 4 and 6 and address register 32
`default_nettype none

module modbus_rtu_response_parser (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire mbrp_pkg::mbrp_in_t                   in_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output mbrp_pkg::mbrp_out_t                      out_data_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [mbrp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [mbrp_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import mbrp_pkg::*;

  mbrp_cfg_t cfg_q;
  logic      s1_valid_q;
  mbrp_in_t  s1_data_q;
  logic      out_valid_q;
  mbrp_out_t out_data_q;

  logic      out_load;
  logic      s1_adv;
  logic      in_acc;
  logic      res_valid;
  mbrp_out_t res;

  assign out_load   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_load;
  assign in_stall_o = s1_valid_q && !out_load;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.read_fc  <= 8'd4;
      cfg_q.write_fc <= 8'd6;
      cfg_q.addr_reg <= 16'd32;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_READ_FC:  cfg_q.read_fc  <= cfg_data_i[7:0];
        CFG_WRITE_FC: cfg_q.write_fc <= cfg_data_i[7:0];
        CFG_ADDR_REG: cfg_q.addr_reg <= cfg_data_i;
        default:      cfg_q          <= cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_data_q <= in_data_i;
    end
  end

  mbrp_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (s1_adv),
    .item_i      (s1_data_q),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= s1_adv && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && s1_adv && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

### sv/mbrp_checker.sv
// mbrp_checker: port-level assertions for modbus_rtu_response_parser
// depends on mbrp_pkg; bound to the top level below
`default_nettype none

module mbrp_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_valid_i,
  input wire logic                            in_stall_o,
  input wire logic                            out_valid_o,
  input wire logic                            out_stall_i,
  input wire mbrp_pkg::mbrp_out_t              out_data_o
);
  import mbrp_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without a transaction two cycles earlier");

  a_data_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind == KIND_DATA
      |-> !out_data_o.frame_ok && out_data_o.frame_type == CLS_DATA)
    else $error("data word with status fields set");

  a_none_not_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind == KIND_STATUS
      && out_data_o.frame_type == CLS_NONE |-> !out_data_o.frame_ok)
    else $error("unrecognized frame reported good");

endmodule

bind modbus_rtu_response_parser mbrp_checker u_mbrp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

### verif/tb_modbus_rtu_response_parser.sv
`timescale 1ns / 100ps
// tb_modbus_rtu_response_parser: self-checking testbench for the modbus rtu response parser
// sends directed and random response frames with crc-16/modbus, checks each result
// against a scoreboard with its own frame predictor; depends on mbrp_pkg and the dut

import mbrp_pkg::*;

class response_checker;
  logic [7:0]  read_fc;
  logic [7:0]  write_fc;
  logic [15:0] addr_reg;

  logic [15:0] crc_acc;
  logic [8:0]  position;
  mbrp_class_e frame_cls;
  logic [7:0]  byte_count;
  logic [23:0] group_bytes;
  logic [5:0]  words_sent;
  logic [7:0]  pending_addr;
  logic        reg_hit;
  logic [7:0]  own_addr;

  mbrp_out_t   expected_results[$];
  int          fails;

  function new();
    read_fc  = 8'd4;
    write_fc = 8'd6;
    addr_reg = 16'd32;
    own_addr = 8'd0;
    fails    = 0;
    clear_frame();
  endfunction

  static function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    return c;
  endfunction

  function void clear_frame();
    crc_acc      = CRC_SEED;
    position     = '0;
    frame_cls    = CLS_NONE;
    byte_count   = '0;
    group_bytes  = '0;
    words_sent   = '0;
    pending_addr = '0;
    reg_hit      = 1'b0;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_READ_FC:  read_fc = data[7:0];
      CFG_WRITE_FC: write_fc = data[7:0];
      CFG_ADDR_REG: addr_reg = data;
      default: ;
    endcase
  endfunction

  // one accepted byte: advance the frame state and queue any result it causes
  function void take_byte(mbrp_in_t item);
    logic [7:0]  b;
    logic [8:0]  p;
    logic [8:0]  off;
    logic [9:0]  total;
    logic [31:0] word;
    logic        emit;
    logic        ok;
    mbrp_class_e cls;
    mbrp_out_t   res;
    b    = item.rx_byte;
    p    = position;
    emit = 1'b0;
    word = '0;
    crc_acc = crc_step(crc_acc, b);
    if (p == 0) begin
      if (b == own_addr) frame_cls = CLS_DATA;
      else if (b == 8'(BROADCAST_ADDRESS)) frame_cls = CLS_ADDR_READ;
      else frame_cls = CLS_NONE;
    end else if (p == 1) begin
      if (frame_cls == CLS_DATA) begin
        frame_cls = (b == read_fc) ? CLS_DATA : CLS_NONE;
      end else if (frame_cls == CLS_ADDR_READ) begin
        if (b == read_fc) frame_cls = CLS_ADDR_READ;
        else if (b == write_fc) frame_cls = CLS_ADDR_WRITE;
        else frame_cls = CLS_NONE;
      end
    end else if (frame_cls == CLS_DATA || frame_cls == CLS_ADDR_READ) begin
      if (p == 2) begin
        byte_count = b;
      end else begin
        off = p - 9'd3;
        if (off < {1'b0, byte_count}) begin
          if (frame_cls == CLS_ADDR_READ) begin
            pending_addr = b;
            reg_hit = 1'b1;
          end else if (off[1:0] != 2'd3) begin
            group_bytes = group_bytes | (24'(b) << (8 * off[1:0]));
          end else begin
            word = {group_bytes[15:8], group_bytes[7:0], b, group_bytes[23:16]};
            group_bytes = '0;
            emit = 1'b1;
          end
        end
      end
    end else if (frame_cls == CLS_ADDR_WRITE) begin
      if (p == 2) group_bytes = 24'(b);
      else if (p == 3) reg_hit = ({group_bytes[7:0], b} == addr_reg);
      else if (p == 5) pending_addr = b;
    end
    if (position < 9'd511) position = position + 9'd1;

    res = '0;
    if (item.frame_end) begin
      total = {1'b0, p} + 10'd1;
      cls = (p < 1) ? CLS_NONE : frame_cls;
      ok = 1'b0;
      if (cls == CLS_DATA || cls == CLS_ADDR_READ) ok = (total == {2'b00, byte_count} + 10'd5);
      else if (cls == CLS_ADDR_WRITE) ok = (total == 10'd8);
      if (total > MAX_FRAME_BYTES || crc_acc != 16'h0000) ok = 1'b0;
      if (ok && cls != CLS_DATA && reg_hit) own_addr = pending_addr;
      res.result_kind     = KIND_STATUS;
      res.value_index     = words_sent;
      res.frame_ok        = ok;
      res.frame_type      = cls;
      res.station_address = own_addr;
      expected_results.push_back(res);
      clear_frame();
    end else if (emit) begin
      res.result_kind     = KIND_DATA;
      res.value_word      = word;
      res.value_index     = words_sent;
      res.frame_type      = CLS_DATA;
      res.station_address = own_addr;
      expected_results.push_back(res);
      words_sent = words_sent + 6'd1;
    end
  endfunction

  function void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s expected %0h actual %0h", name, want, got);
      fails++;
    end
  endfunction

  function void check_result(mbrp_out_t got);
    mbrp_out_t want;
    if (expected_results.size() == 0) begin
      $error("result with no transaction pending: kind %0d word %0h", got.result_kind,
             got.value_word);
      fails++;
      return;
    end
    want = expected_results.pop_front();
    check_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
    check_field("value_word", want.value_word, got.value_word);
    check_field("value_index", 32'(want.value_index), 32'(got.value_index));
    check_field("frame_ok", 32'(want.frame_ok), 32'(got.frame_ok));
    check_field("frame_type", 32'(want.frame_type), 32'(got.frame_type));
    check_field("station_address", 32'(want.station_address), 32'(got.station_address));
  endfunction
endclass

module tb_modbus_rtu_response_parser;
  localparam int QUIET_LIMIT = 2000;
  localparam int PIPE_CYCLES = 4;
  localparam int ITEM_TARGET = 1600;
  localparam int SEGMENTS    = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
  localparam logic [7:0] BCAST_ADDR = 8'(BROADCAST_ADDRESS);

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  mbrp_in_t              in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  mbrp_out_t             out_data_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  response_checker sb;
  int gap_pct = 31;
  int stall_pct = 49;
  int bytes_sent = 0;
  int quiet_cycles = 0;
  logic [7:0] frame_bytes[$];

  modbus_rtu_response_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.take_byte(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{rx_byte: b, frame_end: last};
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.expected_results.size() != 0);
    repeat (PIPE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  task automatic apply_config(input logic [7:0] rfc, input logic [7:0] wfc,
                              input logic [15:0] areg, input logic spare);
    drain_results();
    write_reg(CFG_READ_FC, {8'($urandom), rfc});
    write_reg(CFG_WRITE_FC, {8'($urandom), wfc});
    write_reg(CFG_ADDR_REG, areg);
    if (spare) write_reg(CFG_SPARE_IDX, 16'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  function automatic void start_read(input logic [7:0] addr, input logic [7:0] fc,
                                     input logic [7:0] count, input int ndata);
    frame_bytes = {addr, fc, count};
    repeat (ndata) frame_bytes.push_back(8'($urandom));
  endfunction

  function automatic void seal_frame();
    logic [15:0] c;
    c = CRC_SEED;
    foreach (frame_bytes[i]) c = crc_byte(c, frame_bytes[i]);
    frame_bytes.push_back(c[7:0]);
    frame_bytes.push_back(c[15:8]);
  endfunction

  task automatic random_frame();
    int sel;
    int n;
    int idx;
    logic [7:0] own;
    logic [15:0] reg_no;
    own = sb.own_addr;
    sel = $urandom_range(99);
    n = ($urandom_range(29) == 0) ? $urandom_range(25, 96) : $urandom_range(0, 24);
    if (sel < 55) begin
      start_read(own, sb.read_fc, 8'(n), n);
      seal_frame();
    end else if (sel < 63) begin
      n = $urandom_range(0, 4);
      start_read(BCAST_ADDR, sb.read_fc, 8'(n), n);
      seal_frame();
    end else if (sel < 72) begin
      reg_no = $urandom_range(1) ? sb.addr_reg : 16'($urandom);
      frame_bytes = {($urandom_range(1) ? BCAST_ADDR : own), sb.write_fc, reg_no[15:8],
                     reg_no[7:0], 8'($urandom), 8'($urandom)};
      seal_frame();
    end else if (sel < 85) begin
      start_read(own, sb.read_fc, 8'(n), n);
      seal_frame();
      case ($urandom_range(3))
        0: begin
          idx = $urandom_range(frame_bytes.size() - 1);
          frame_bytes[idx] = frame_bytes[idx] ^ 8'(1 << $urandom_range(7));
        end
        1: void'(frame_bytes.pop_back());
        2: frame_bytes.push_back(8'($urandom));
        default: begin
          start_read(own, sb.read_fc, 8'(n), n + 1);
          seal_frame();
        end
      endcase
    end else if (sel < 92) begin
      if ($urandom_range(1)) start_read(own + 8'(1 + $urandom_range(254)), 8'($urandom), 8'(n), n);
      else start_read(own, 8'($urandom), 8'(n), n);
      seal_frame();
    end else begin
      frame_bytes = {};
      repeat ($urandom_range(1, 10)) frame_bytes.push_back(8'($urandom));
      if ($urandom_range(1)) seal_frame();
    end
    send_frame();
  endtask

  initial begin
    int target;
    int share;
    logic [7:0] clash_fc;
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed frames under the reset configuration
    start_read(8'h00, sb.read_fc, 8'd8, 8);
    frame_bytes[3] = 8'hFF;
    frame_bytes[4] = 8'h00;
    frame_bytes[5] = 8'hA5;
    frame_bytes[6] = 8'h5A;
    seal_frame();
    send_frame();
    start_read(8'h00, sb.read_fc, 8'd0, 0);
    seal_frame();
    send_frame();
    // group completes on the closing byte
    start_read(8'h00, sb.read_fc, 8'd4, 4);
    send_frame();
    start_read(8'h00, sb.read_fc, 8'd6, 6);
    seal_frame();
    send_frame();
    frame_bytes = {8'h00};
    send_frame();
    frame_bytes = {8'h37};
    send_frame();
    frame_bytes = {8'h00, sb.read_fc};
    send_frame();
    frame_bytes = {BCAST_ADDR, sb.write_fc, sb.addr_reg[15:8], sb.addr_reg[7:0], 8'h00, 8'h5A};
    seal_frame();
    send_frame();
    start_read(8'hFF, sb.read_fc, 8'd2, 2);
    seal_frame();
    send_frame();
    start_read(8'h00, sb.read_fc, 8'd4, 4);
    seal_frame();
    frame_bytes[frame_bytes.size() - 1] = frame_bytes[frame_bytes.size() - 1] ^ 8'h80;
    send_frame();
    // overlong frames, the second one past the position limit
    start_read(8'h00, sb.read_fc, 8'd255, 255);
    seal_frame();
    send_frame();
    start_read(8'h00, sb.read_fc, 8'd255, 515);
    seal_frame();
    send_frame();

    share = (ITEM_TARGET - bytes_sent) / SEGMENTS;
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < 2) begin
        gap_pct = 31;
        stall_pct = 49;
      end else if (seg < 4) begin
        gap_pct = 49;
        stall_pct = 31;
      end else begin
        gap_pct = 0;
        stall_pct = 0;
      end
      clash_fc = 8'($urandom);
      case (seg)
        0: apply_config(8'd4, 8'd6, 16'd32, 1'b1);
        1: apply_config(8'hFF, 8'hFF, 16'hFFFF, 1'b0);
        2: apply_config(8'h00, 8'h00, 16'h0000, 1'b0);
        3: apply_config(8'($urandom), 8'($urandom), 16'($urandom), 1'b1);
        4: apply_config(clash_fc, clash_fc, 16'($urandom), 1'b0);
        default: apply_config(8'd4, 8'd6, 16'd32, 1'b0);
      endcase
      target = bytes_sent + share;
      while (bytes_sent < target) begin
        if ($urandom_range(99) < 3) drain_results();
        random_frame();
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (sb.fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
